// ===== src/sparse_table_range_minimum_top_assert.svh =====
// Assertion macros used by the range-minimum block checker
`ifndef SPARSE_TABLE_RANGE_MINIMUM_TOP_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define STRMQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check a consequence in the cycle after its trigger
`define STRMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/strmq_pkg.sv =====
// Package: field widths, stream packing offsets and codes of the range-minimum block
`default_nettype none

package strmq_pkg;

  // Field widths fixed by the stream format
  localparam int POS_W  = 11;
  localparam int VAL_W  = 16;
  localparam int FUNC_W = 1;

  // Input tdata: value, left_index, right_index from the lowest bit up
  localparam int IN_VALUE_LSB = 0;
  localparam int IN_LEFT_LSB  = IN_VALUE_LSB + VAL_W;
  localparam int IN_RIGHT_LSB = IN_LEFT_LSB + POS_W;
  localparam int IN_TDATA_W   = ((VAL_W + 2 * POS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = FUNC_W;

  // Output tdata: min_position, min_value from the lowest bit up
  localparam int OUT_POS_LSB = 0;
  localparam int OUT_VAL_LSB = OUT_POS_LSB + POS_W;
  localparam int OUT_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - VAL_W;
  localparam int OUT_TUSER_W = 1;

  // Default sizing
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEVELS       = 11;
  localparam int DEF_VALUE_BITS   = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

endpackage

`default_nettype wire

// ===== src/sparse_table_range_minimum_top.sv =====
// Sparse-table range-minimum engine: loader, table build sequencer and query unit
// Load: one item per cycle, ready again the next cycle; no result.
// Last load: then a table build, one entry at a time, read in S_BRD and written in S_BWR
//   through the table memory's two read ports and one shared comparator; not ready.
// Query: S_QCHK, S_QLOG, S_QRD, S_QCMP (bad range: S_QCHK only); next item taken on return to idle.
// Reset (rst_n low, synchronous) empties the sequence and drops the built table; no clearing pass.
`default_nettype none

module sparse_table_range_minimum_top #(
  parameter int MAX_ELEMENTS = strmq_pkg::DEF_MAX_ELEMENTS,
  parameter int LEVELS       = strmq_pkg::DEF_LEVELS,
  parameter int VALUE_BITS   = strmq_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [strmq_pkg::IN_TDATA_W-1:0]  in_tdata,   // value, left_index, right_index, pad
  input  logic [strmq_pkg::IN_TUSER_W-1:0]  in_tuser,   // func
  input  logic                              in_tlast,   // last
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [strmq_pkg::OUT_TDATA_W-1:0] out_tdata,  // min_position, min_value, pad
  output logic [strmq_pkg::OUT_TUSER_W-1:0] out_tuser   // error
);
  import strmq_pkg::*;

  // Position counter holds 0..MAX_ELEMENTS; table index is position - 1
  localparam int PW     = $clog2(MAX_ELEMENTS + 1);
  localparam int IW     = $clog2(MAX_ELEMENTS);
  localparam int LW     = $clog2(LEVELS);
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int AW     = LW + IW;
  localparam int TDEPTH = LEVELS * (2 ** IW);
  // Each table entry carries the winning position and its value
  localparam int EW     = PW + VALUE_BITS;
  localparam int CW     = (PW > POS_W) ? PW : POS_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LEVEL = 8'b0000_0010,
    S_BRD   = 8'b0000_0100,
    S_BWR   = 8'b0000_1000,
    S_QCHK  = 8'b0001_0000,
    S_QLOG  = 8'b0010_0000,
    S_QRD   = 8'b0100_0000,
    S_QCMP  = 8'b1000_0000
  } state_t;

  state_t              state_r;
  logic [PW-1:0]       load_cnt_r;
  logic [PW-1:0]       load_cnt_nxt;
  logic [PW-1:0]       count_r;
  logic                ready_r;
  logic [LVW-1:0]      lvl_r;
  logic [LVW-1:0]      lvl_m1;
  logic [PW:0]         span_r;
  logic [IW-1:0]       idx_r;
  logic [PW-1:0]       lim_r;
  logic [POS_W-1:0]    l_r;
  logic [POS_W-1:0]    r_r;
  logic [CW-1:0]       len_r;
  logic [LW-1:0]       k_r;
  logic [LW-1:0]       k_nxt;
  int                  k_msb;

  logic [EW-1:0]       table_mem [0:TDEPTH-1];
  logic [EW-1:0]       rd_a_r;
  logic [EW-1:0]       rd_b_r;
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;

  logic                out_tvalid_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [VAL_W-1:0]    out_val_r;
  logic                out_err_r;

  logic                in_acc;
  logic                is_load;
  logic                not_full;
  logic                out_free;
  logic                res_fire;
  logic                q_bad;
  logic [POS_W-1:0]    in_left;
  logic [POS_W-1:0]    in_right;
  logic [VALUE_BITS-1:0] ld_val;
  logic [CW-1:0]       q_a_idx;
  logic [CW-1:0]       q_b_idx;
  logic [PW:0]         b_idx;
  logic [EW-1:0]       win;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_load   = in_acc && (in_tuser[0] == FUNC_LOAD);
  assign in_left   = in_tdata[IN_LEFT_LSB +: POS_W];
  assign in_right  = in_tdata[IN_RIGHT_LSB +: POS_W];
  assign ld_val    = VALUE_BITS'(in_tdata[IN_VALUE_LSB +: VAL_W]);

  // Drop values once the store is full; the count then stays at its maximum
  assign not_full     = (load_cnt_r < PW'(MAX_ELEMENTS));
  assign load_cnt_nxt = not_full ? (load_cnt_r + 1'b1) : load_cnt_r;

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_tvalid_r || out_tready;

  // Launch a result: a bad range from the check, a good one from the compare
  assign res_fire = out_free && (((state_r == S_QCHK) && q_bad) || (state_r == S_QCMP));

  // ---------------------------------------------------------------------------
  // Query arithmetic (ends already ordered in l_r <= r_r)
  // ---------------------------------------------------------------------------
  assign q_bad   = !ready_r || (l_r == '0) || (CW'(r_r) > CW'(count_r));
  assign q_a_idx = CW'(l_r) - CW'(1);
  assign q_b_idx = CW'(r_r) - (CW'(1) << k_r);

  // Window level: highest set bit of the range length, capped at the top level
  always_comb begin
    k_msb = 0;
    for (int b = 0; b < CW; b++) begin
      if (len_r[b]) begin
        k_msb = b;
      end
    end
    if (k_msb > LEVELS - 1) begin
      k_nxt = LW'(LEVELS - 1);
    end else begin
      k_nxt = LW'(k_msb);
    end
  end

  // ---------------------------------------------------------------------------
  // Build arithmetic: level j entry i merges level j-1 entries i and i + 2^(j-1)
  // ---------------------------------------------------------------------------
  assign lvl_m1 = lvl_r - 1'b1;
  assign b_idx  = (PW + 1)'(idx_r) + (span_r >> 1);

  // ---------------------------------------------------------------------------
  // Shared comparator: the later window wins unless the earlier one is strictly smaller
  // ---------------------------------------------------------------------------
  assign win = (rd_a_r[VALUE_BITS-1:0] < rd_b_r[VALUE_BITS-1:0]) ? rd_a_r : rd_b_r;

  // ---------------------------------------------------------------------------
  // Table memory: level-major, one write and two registered reads per cycle
  // ---------------------------------------------------------------------------
  // Keep the query addresses through the compare so a stalled winner reads back unchanged
  always_comb begin
    if ((state_r == S_QRD) || (state_r == S_QCMP)) begin
      rd_addr_a = {k_r, q_a_idx[IW-1:0]};
      rd_addr_b = {k_r, q_b_idx[IW-1:0]};
    end else begin
      rd_addr_a = {lvl_m1[LW-1:0], idx_r};
      rd_addr_b = {lvl_m1[LW-1:0], b_idx[IW-1:0]};
    end
  end

  // Level 0 is filled straight from the loads; higher levels by the build
  always_comb begin
    if (state_r == S_BWR) begin
      wr_en   = 1'b1;
      wr_addr = {lvl_r[LW-1:0], idx_r};
      wr_data = win;
    end else begin
      wr_en   = is_load && not_full;
      wr_addr = {{LW{1'b0}}, load_cnt_r[IW-1:0]};
      wr_data = {load_cnt_nxt, ld_val};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= table_mem[rd_addr_a];
    rd_b_r <= table_mem[rd_addr_b];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      load_cnt_r   <= '0;
      count_r      <= '0;
      ready_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (res_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (is_load) begin
            // A fresh sequence drops the old table
            if (load_cnt_r == '0) begin
              ready_r <= 1'b0;
            end
            if (in_tlast) begin
              count_r    <= load_cnt_nxt;
              load_cnt_r <= '0;
              lvl_r      <= LVW'(1);
              span_r     <= (PW + 1)'(2);
              state_r    <= S_LEVEL;
            end else begin
              load_cnt_r <= load_cnt_nxt;
            end
          end else if (in_acc) begin
            // Order the ends so that l_r is the smaller
            if (in_left > in_right) begin
              l_r <= in_right;
              r_r <= in_left;
            end else begin
              l_r <= in_left;
              r_r <= in_right;
            end
            state_r <= S_QCHK;
          end
        end
        S_LEVEL: begin
          if ((lvl_r < LVW'(LEVELS)) && (span_r <= (PW + 1)'(count_r))) begin
            idx_r   <= '0;
            lim_r   <= PW'((PW + 1)'(count_r) - span_r);
            state_r <= S_BRD;
          end else begin
            ready_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_BRD: begin
          state_r <= S_BWR;
        end
        S_BWR: begin
          if (PW'(idx_r) == lim_r) begin
            lvl_r   <= lvl_r + 1'b1;
            span_r  <= span_r << 1;
            state_r <= S_LEVEL;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_BRD;
          end
        end
        S_QCHK: begin
          if (q_bad) begin
            if (out_free) begin
              out_pos_r <= '0;
              out_val_r <= '0;
              out_err_r <= 1'b1;
              state_r   <= S_IDLE;
            end
          end else begin
            len_r   <= CW'(r_r) - CW'(l_r) + CW'(1);
            state_r <= S_QLOG;
          end
        end
        S_QLOG: begin
          k_r     <= k_nxt;
          state_r <= S_QRD;
        end
        S_QRD: begin
          state_r <= S_QCMP;
        end
        S_QCMP: begin
          // Hold the winner in the read registers until the result slot frees
          if (out_free) begin
            out_pos_r <= POS_W'(win[EW-1:VALUE_BITS]);
            out_val_r <= VAL_W'(win[VALUE_BITS-1:0]);
            out_err_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {{OUT_PAD_W{1'b0}}, out_val_r, out_pos_r};
  assign out_tuser[0] = out_err_r;

endmodule

`default_nettype wire

// ===== src/strmq_checker.sv =====
// Port-level checker for the range-minimum block, bound to its top level
`default_nettype none
`include "sparse_table_range_minimum_top_assert.svh"

module strmq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [strmq_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [strmq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [strmq_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import strmq_pkg::*;

  logic                                in_acc;
  logic [OUT_TUSER_W+OUT_TDATA_W-1:0] out_word;

  assign in_acc   = in_tvalid && in_tready;
  assign out_word = {out_tuser, out_tdata};

  // A stalled result holds
  `STRMQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // An error result carries zero position and value
  `STRMQ_ASSERT_SAME(a_err_zero, out_tvalid && out_tuser[0], out_tdata == '0)

  // A good result names a real position
  `STRMQ_ASSERT_SAME(a_pos_nonzero, out_tvalid && !out_tuser[0], out_tdata[POS_W-1:0] != '0)

  // A load never produces a result
  `STRMQ_ASSERT_NEXT(a_load_silent, in_acc && (in_tuser[0] == FUNC_LOAD) && !out_tvalid, !out_tvalid)

  // A query keeps the block busy for at least the following cycle
  `STRMQ_ASSERT_NEXT(a_query_busy, in_acc && (in_tuser[0] == FUNC_QUERY), !in_tready)

endmodule

bind sparse_table_range_minimum_top strmq_checker u_strmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/sv/sparse_table_range_minimum_top_test.sv =====
// Self-checking stream testbench for the sparse-table range-minimum engine
`default_nettype none

module sparse_table_range_minimum_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import strmq_pkg::*;

  localparam int MAXE       = DEF_MAX_ELEMENTS;
  localparam int LEV        = DEF_LEVELS;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int IDLE_PCT   = 37;
  localparam int RANDOM_REQ = 200;
  localparam int DRAIN_WAIT = 100;
  localparam int HOLD_LEN   = 600;
  localparam int HOLD_AT    = 10;

  // One request on the input channel
  typedef struct packed {
    func_t            func;
    logic [VAL_W-1:0] value;
    logic             last;
    logic [POS_W-1:0] left_idx;
    logic [POS_W-1:0] right_idx;
  } rmq_request_t;

  // One answer on the result channel
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             err;
  } min_answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // value, left_index, right_index, pad
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // func
  logic                   in_tlast = 1'b0; // last
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // min_position, min_value, pad
  logic [OUT_TUSER_W-1:0] out_tuser;       // error

  sparse_table_range_minimum_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Pending requests for the driver and answers still owed by the block
  rmq_request_t request_q[$];
  min_answer_t  answer_q[$];

  // Shadow of the engine's state, kept in step with accepted requests
  logic [VAL_W-1:0] depth_store [0:MAXE];
  logic [POS_W-1:0] argmin_pos  [0:LEV-1][0:MAXE];
  int unsigned      seq_count;
  int unsigned      open_count;
  bit               table_built;

  // Generator's own view of the sequence, used only to aim queries
  int unsigned gen_count;
  int unsigned gen_open;

  int  fail_count;
  int  cycle_count;
  int  requests_taken;
  int  results_seen;
  bit  in_accepted;
  int  hold_left;
  bit  hold_done;

  // Fill every window level; on a tie the later window wins
  task automatic build_argmin(int unsigned n);
    int unsigned i;
    int unsigned j;
    int unsigned half;
    int unsigned span;
    int unsigned a;
    int unsigned b;
    for (i = 1; i <= n; i++) argmin_pos[0][i] = POS_W'(i);
    for (j = 1; j < LEV && (1 << j) <= n; j++) begin
      half = 1 << (j - 1);
      span = 1 << j;
      for (i = 1; i + span - 1 <= n; i++) begin
        a = argmin_pos[j-1][i];
        b = argmin_pos[j-1][i+half];
        argmin_pos[j][i] = (depth_store[a] < depth_store[b]) ? POS_W'(a) : POS_W'(b);
      end
    end
  endtask

  // Advance the shadow state by one accepted request; queue any answer it owes
  task automatic absorb_request(rmq_request_t req);
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    int unsigned k;
    int unsigned a;
    int unsigned b;
    int unsigned p;
    min_answer_t ans;
    if (req.func == FUNC_LOAD) begin
      // a load that opens a sequence drops the built table
      if (open_count == 0) table_built = 1'b0;
      // once the store is full, further values are dropped
      if (open_count < MAXE) begin
        open_count++;
        depth_store[open_count] = req.value;
      end
      if (req.last) begin
        seq_count = open_count;
        build_argmin(seq_count);
        table_built = 1'b1;
        open_count  = 0;
      end
    end else begin
      lo = (req.left_idx <= req.right_idx) ? req.left_idx : req.right_idx;
      hi = (req.left_idx <= req.right_idx) ? req.right_idx : req.left_idx;
      if (!table_built || lo == 0 || hi > seq_count) begin
        ans = '{pos: '0, val: '0, err: 1'b1};
      end else begin
        len = hi - lo + 1;
        k   = 0;
        while (k + 1 < LEV && (1 << (k + 1)) <= len) k++;
        a = argmin_pos[k][lo];
        b = argmin_pos[k][hi - (1 << k) + 1];
        p = (depth_store[a] < depth_store[b]) ? a : b;
        ans = '{pos: POS_W'(p), val: depth_store[p], err: 1'b0};
      end
      answer_q = {answer_q, ans};
    end
  endtask

  // Queue a load; the unused query fields carry random bits
  task automatic push_load(logic [VAL_W-1:0] v, bit lst);
    rmq_request_t req;
    req = '{func: FUNC_LOAD, value: v, last: lst,
            left_idx: POS_W'($urandom), right_idx: POS_W'($urandom)};
    request_q = {request_q, req};
  endtask

  // Queue a query; the unused value and last fields carry random bits
  task automatic push_query(int unsigned l, int unsigned r);
    rmq_request_t req;
    req = '{func: FUNC_QUERY, value: VAL_W'($urandom), last: 1'($urandom),
            left_idx: POS_W'(l), right_idx: POS_W'(r)};
    request_q = {request_q, req};
  endtask

  function automatic logic [VAL_W-1:0] draw_depth(bit narrow);
    return narrow ? VAL_W'($urandom_range(0, 3)) : VAL_W'($urandom);
  endfunction

  // Aim mostly at valid ranges of the built sequence, with some noise
  task automatic push_aimed_queries(int unsigned cnt);
    int unsigned q;
    int unsigned mode;
    int unsigned l;
    for (q = 0; q < cnt; q++) begin
      mode = $urandom_range(0, 9);
      if (gen_count == 0 || mode == 0) begin
        push_query($urandom_range(0, 2047), $urandom_range(0, 2047));
      end else if (mode == 1) begin
        l = $urandom_range(0, gen_count);
        push_query(l, gen_count + 1);
      end else if (mode == 2) begin
        push_query(1, gen_count);
      end else if (mode == 3) begin
        l = $urandom_range(1, gen_count);
        push_query(l, l);
      end else begin
        push_query($urandom_range(1, gen_count), $urandom_range(1, gen_count));
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Stimulus: directed corners, then a full store, then random sequences
  initial begin : stimulus
    int unsigned n;
    int unsigned i;
    int unsigned made;
    bit          narrow;
    seq_count   = 0;
    open_count  = 0;
    table_built = 1'b0;
    gen_count   = 0;
    gen_open    = 0;

    // query before any build must flag an error
    push_query(1, 1);
    // four values with a tie for the minimum at positions 2 and 4
    push_load(16'd5, 1'b0);
    push_load(16'd0, 1'b0);
    push_load(16'hFFFF, 1'b0);
    push_load(16'd0, 1'b1);
    push_query(1, 4);
    push_query(4, 1);
    push_query(2, 2);
    push_query(0, 3);
    push_query(3, 5);
    push_query(2047, 2047);
    push_query(1, 2);
    push_query(3, 4);
    // open a new sequence: the old table is gone until the next build
    push_load(16'd7, 1'b0);
    push_query(1, 1);
    push_load(16'd9, 1'b1);
    push_query(2, 1);
    push_query(1, 2);
    // single-element sequence at the top value
    push_load(16'hFFFF, 1'b1);
    push_query(1, 1);
    push_query(1, 2);
    push_query(0, 0);

    // overfill the store: the surplus values are dropped, build covers it all
    narrow = 1'b1;
    for (i = 1; i <= MAXE + 2; i++) push_load(draw_depth(narrow), i == MAXE + 2);
    gen_count = MAXE;
    push_query(1, MAXE);
    push_query(MAXE, 1);
    push_query(MAXE, MAXE);
    push_query(1, MAXE + 1);
    push_query(MAXE + 1, 2047);
    push_aimed_queries(35);

    // random part: mostly well-formed sequences, some broken ones
    made = 0;
    while (made < RANDOM_REQ) begin
      if ($urandom_range(0, 99) < 85) begin
        i = $urandom_range(0, 99);
        n = (i < 70) ? $urandom_range(1, 16) :
            (i < 95) ? $urandom_range(17, 64) : $urandom_range(65, 200);
        narrow = 1'($urandom);
        for (i = 1; i <= n; i++) push_load(draw_depth(narrow), i == n);
        gen_count = (gen_open + n > MAXE) ? MAXE : gen_open + n;
        gen_open  = 0;
        i = $urandom_range(3, 20);
        push_aimed_queries(i);
        made += n + i;
      end else begin
        // loads left open, then queries that must all flag an error
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_load(draw_depth(1'($urandom)), 1'b0);
        gen_open += n;
        i = $urandom_range(1, 3);
        push_aimed_queries(i);
        made += n + i;
      end
    end

    // hold reset low, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: every request taken, every answer returned, then a quiet tail
    while (request_q.size() != 0 || in_tvalid) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sparse_table_range_minimum_top: PASSED **");
    end else begin
      $display("** sparse_table_range_minimum_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: abandon the run at the cycle cap
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("** sparse_table_range_minimum_top: FAILED **");
      $finish;
    end
  end

  // Input side at the rising edge: note each accepted request and predict it
  always @(posedge clk) begin : take_requests
    rmq_request_t req;
    in_accepted = rst_n && in_tvalid && in_tready;
    if (in_accepted) begin
      req.func      = func_t'(in_tuser[0]);
      req.value     = in_tdata[IN_VALUE_LSB +: VAL_W];
      req.last      = in_tlast;
      req.left_idx  = in_tdata[IN_LEFT_LSB +: POS_W];
      req.right_idx = in_tdata[IN_RIGHT_LSB +: POS_W];
      absorb_request(req);
      requests_taken++;
    end
  end

  // Driver at the falling edge: hold a request until taken, idle at random outside a steady window
  always @(negedge clk) begin : drive_requests
    logic [IN_TDATA_W-1:0] word;
    rmq_request_t          req;
    bit                    steady;
    steady = requests_taken >= 300 && requests_taken < 600;
    if (rst_n && (!in_tvalid || in_accepted)) begin
      if (request_q.size() == 0 || (!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
        in_tvalid <= 1'b0;
      end else begin
        req  = request_q.pop_front();
        word = '0;
        word[IN_VALUE_LSB +: VAL_W] = req.value;
        word[IN_LEFT_LSB  +: POS_W] = req.left_idx;
        word[IN_RIGHT_LSB +: POS_W] = req.right_idx;
        in_tdata  <= word;
        in_tuser  <= req.func;
        in_tlast  <= req.last;
        in_tvalid <= 1'b1;
      end
    end
  end

  // Receiver at the falling edge: random stalls outside a steady window, one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
      hold_done  <= 1'b1;
    end else if (results_seen >= 20 && results_seen < 50) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor at the rising edge: compare each answer with the oldest prediction
  always @(posedge clk) begin : check_answers
    min_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (answer_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual pos %0d val %0d err %0d",
                 $time, out_tdata[OUT_POS_LSB +: POS_W], out_tdata[OUT_VAL_LSB +: VAL_W],
                 out_tuser[0]);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        check_field("min_position", want.pos, out_tdata[OUT_POS_LSB +: POS_W]);
        check_field("min_value", want.val, out_tdata[OUT_VAL_LSB +: VAL_W]);
        check_field("error", want.err, out_tuser[0]);
      end
    end
  end

endmodule

`default_nettype wire
